### design/page_mapped_ftl_greedy_gc_macros.svh
// Assertion macros for the top-level module
`ifndef PAGE_MAPPED_FTL_GREEDY_GC_MACROS_SVH
`define PAGE_MAPPED_FTL_GREEDY_GC_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset
`define FTLGC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FTLGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ftlgc_pkg.sv
package ftlgc_pkg;

    // Geometry
    localparam int LBA_COUNT     = 64;
    localparam int BLOCK_COUNT   = 16;
    localparam int PAGES_PER_BLK = 8;
    localparam int TOTAL_PAGES   = BLOCK_COUNT * PAGES_PER_BLK;

    // Widths set by the request and result fields
    localparam int BLK_W  = 4;
    localparam int PG_W   = 3;
    localparam int LBAF_W = 7;
    localparam int CNT_W  = 16;
    localparam int THR_W  = 5;

    // Derived widths
    localparam int LBA_W = (LBA_COUNT > 1) ? $clog2(LBA_COUNT) : 1;
    localparam int PA_W  = $clog2(TOTAL_PAGES);
    localparam int WP_W  = $clog2(PAGES_PER_BLK + 1);
    localparam int FC_W  = $clog2(BLOCK_COUNT + 1);

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TRIM  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        K_WRITE = 3'd0,
        K_READ  = 3'd1,
        K_TRIM  = 3'd2,
        K_RELOC = 3'd3,
        K_ERASE = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LBA = 2'd1,
        ST_UNMAP   = 2'd2,
        ST_NOSPACE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PG_FREE    = 2'd0,
        PG_VALID   = 2'd1,
        PG_INVALID = 2'd2,
        PG_RSVD    = 2'd3
    } t_pstate;

    // Source of the location fields of a result
    typedef enum logic [1:0] {
        ES_ZERO  = 2'd0,
        ES_MAP   = 2'd1,
        ES_PROG  = 2'd2,
        ES_ERASE = 2'd3
    } t_esrc;

    // Source of the lba field of a result
    typedef enum logic [1:0] {
        LS_HOST  = 2'd0,
        LS_OWNER = 2'd1,
        LS_ZERO  = 2'd2
    } t_lsel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MAP,
        S_GCSCAN,
        S_RRD,
        S_RCHK,
        S_RSCAN,
        S_RPROG,
        S_REMIT,
        S_ERASE,
        S_OPEN,
        S_OSCAN,
        S_PROG,
        S_PEMIT
    } t_state;

    typedef struct packed {
        logic [1:0]        action;
        logic [LBAF_W-1:0] lba;
    } t_req;

    typedef struct packed {
        logic [2:0]        kind;
        logic [1:0]        status;
        logic [LBAF_W-1:0] out_lba;
        logic [BLK_W-1:0]  phys_block;
        logic [PG_W-1:0]   phys_page;
        logic              mapped;
        logic [CNT_W-1:0]  host_writes;
        logic [CNT_W-1:0]  nand_programs;
        logic [CNT_W-1:0]  gc_runs;
        logic              last;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic       latch;
        logic       map_rd;
        logic       unmap_old;
        logic       hw_inc;
        logic       gc_inc;
        logic       scan_start;
        logic       rp_clr;
        logic       rp_inc;
        logic       ps_rd;
        logic       open_take;
        logic       open_kill;
        logic       prog;
        logic       prog_reloc;
        logic       erase;
        logic       emit;
        logic [2:0] e_kind;
        logic [1:0] e_status;
        t_esrc      e_src;
        t_lsel      e_lsel;
        logic       e_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       lba_bad;
        logic       map_hit;
        logic       open_room;
        logic       scan_done;
        logic       gc_need;
        logic       vic_ok;
        logic       first_ok;
        logic       pg_valid;
        logic       rp_last;
    } t_sts;

    // Flat page address of a block and page
    function automatic logic [PA_W-1:0] pidx(input logic [BLK_W-1:0] b,
                                             input logic [PG_W-1:0] p);
        int v;
        v = int'(b) * PAGES_PER_BLK + int'(p);
        return v[PA_W-1:0];
    endfunction

endpackage

### design/ftlgc_ctrl.sv
module ftlgc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ftlgc_pkg::t_sts   i_sts,
    output ftlgc_pkg::t_cmd   o_cmd,
    output logic              busy
);

    ftlgc_pkg::t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftlgc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ftlgc_pkg::S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ftlgc_pkg::S_IDLE: begin
                if (start) n_state = ftlgc_pkg::S_DECODE;
            end
            ftlgc_pkg::S_DECODE: begin
                if (i_sts.action == ftlgc_pkg::ACT_NONE || i_sts.lba_bad) begin
                    n_state = ftlgc_pkg::S_IDLE;
                end else begin
                    n_state = ftlgc_pkg::S_MAP;
                end
            end
            ftlgc_pkg::S_MAP: begin
                if (i_sts.action != ftlgc_pkg::ACT_WRITE) n_state = ftlgc_pkg::S_IDLE;
                else if (i_sts.open_room) n_state = ftlgc_pkg::S_PROG;
                else n_state = ftlgc_pkg::S_GCSCAN;
            end
            ftlgc_pkg::S_GCSCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.gc_need && i_sts.vic_ok) n_state = ftlgc_pkg::S_RRD;
                    else n_state = ftlgc_pkg::S_OPEN;
                end
            end
            ftlgc_pkg::S_RRD: n_state = ftlgc_pkg::S_RCHK;
            ftlgc_pkg::S_RCHK: begin
                if (i_sts.pg_valid) begin
                    n_state = i_sts.open_room ? ftlgc_pkg::S_RPROG : ftlgc_pkg::S_RSCAN;
                end else begin
                    n_state = i_sts.rp_last ? ftlgc_pkg::S_ERASE : ftlgc_pkg::S_RRD;
                end
            end
            ftlgc_pkg::S_RSCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.first_ok ? ftlgc_pkg::S_RPROG : ftlgc_pkg::S_OPEN;
                end
            end
            ftlgc_pkg::S_RPROG: n_state = ftlgc_pkg::S_REMIT;
            ftlgc_pkg::S_REMIT: begin
                n_state = i_sts.rp_last ? ftlgc_pkg::S_ERASE : ftlgc_pkg::S_RRD;
            end
            ftlgc_pkg::S_ERASE: n_state = ftlgc_pkg::S_OPEN;
            ftlgc_pkg::S_OPEN: begin
                n_state = i_sts.open_room ? ftlgc_pkg::S_PROG : ftlgc_pkg::S_OSCAN;
            end
            ftlgc_pkg::S_OSCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.first_ok ? ftlgc_pkg::S_PROG : ftlgc_pkg::S_IDLE;
                end
            end
            ftlgc_pkg::S_PROG:  n_state = ftlgc_pkg::S_PEMIT;
            ftlgc_pkg::S_PEMIT: n_state = ftlgc_pkg::S_IDLE;
            default:            n_state = ftlgc_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.e_src    = ftlgc_pkg::ES_ZERO;
        o_cmd.e_lsel   = ftlgc_pkg::LS_HOST;
        case (r_state)
            ftlgc_pkg::S_IDLE: begin
                o_cmd.latch = start;
            end
            ftlgc_pkg::S_DECODE: begin
                if (i_sts.action != ftlgc_pkg::ACT_NONE) begin
                    if (i_sts.lba_bad) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.e_kind   = {1'b0, i_sts.action};
                        o_cmd.e_status = ftlgc_pkg::ST_BAD_LBA;
                        o_cmd.e_last   = 1'b1;
                    end else begin
                        o_cmd.map_rd = 1'b1;
                    end
                end
            end
            ftlgc_pkg::S_MAP: begin
                o_cmd.unmap_old = i_sts.map_hit && (i_sts.action != ftlgc_pkg::ACT_READ);
                if (i_sts.action == ftlgc_pkg::ACT_WRITE) begin
                    o_cmd.hw_inc     = 1'b1;
                    o_cmd.scan_start = !i_sts.open_room;
                end else begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.e_last   = 1'b1;
                    o_cmd.e_status = i_sts.map_hit ? ftlgc_pkg::ST_OK : ftlgc_pkg::ST_UNMAP;
                    if (i_sts.action == ftlgc_pkg::ACT_READ) begin
                        o_cmd.e_kind = ftlgc_pkg::K_READ;
                        o_cmd.e_src  = i_sts.map_hit ? ftlgc_pkg::ES_MAP : ftlgc_pkg::ES_ZERO;
                    end else begin
                        o_cmd.e_kind = ftlgc_pkg::K_TRIM;
                    end
                end
            end
            ftlgc_pkg::S_GCSCAN: begin
                if (i_sts.scan_done && i_sts.gc_need) begin
                    o_cmd.gc_inc = 1'b1;
                    o_cmd.rp_clr = 1'b1;
                end
            end
            ftlgc_pkg::S_RRD: begin
                o_cmd.ps_rd = 1'b1;
            end
            ftlgc_pkg::S_RCHK: begin
                if (i_sts.pg_valid) begin
                    o_cmd.scan_start = !i_sts.open_room;
                end else begin
                    o_cmd.rp_inc = !i_sts.rp_last;
                end
            end
            ftlgc_pkg::S_RSCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.first_ok) begin
                        o_cmd.open_take = 1'b1;
                    end else begin
                        o_cmd.open_kill = 1'b1;
                        o_cmd.emit      = 1'b1;
                        o_cmd.e_kind    = ftlgc_pkg::K_RELOC;
                        o_cmd.e_status  = ftlgc_pkg::ST_NOSPACE;
                        o_cmd.e_lsel    = ftlgc_pkg::LS_OWNER;
                    end
                end
            end
            ftlgc_pkg::S_RPROG: begin
                o_cmd.prog       = 1'b1;
                o_cmd.prog_reloc = 1'b1;
            end
            ftlgc_pkg::S_REMIT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.e_kind   = ftlgc_pkg::K_RELOC;
                o_cmd.e_status = ftlgc_pkg::ST_OK;
                o_cmd.e_src    = ftlgc_pkg::ES_PROG;
                o_cmd.e_lsel   = ftlgc_pkg::LS_OWNER;
                o_cmd.rp_inc   = !i_sts.rp_last;
            end
            ftlgc_pkg::S_ERASE: begin
                o_cmd.erase    = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.e_kind   = ftlgc_pkg::K_ERASE;
                o_cmd.e_status = ftlgc_pkg::ST_OK;
                o_cmd.e_src    = ftlgc_pkg::ES_ERASE;
                o_cmd.e_lsel   = ftlgc_pkg::LS_ZERO;
            end
            ftlgc_pkg::S_OPEN: begin
                o_cmd.scan_start = !i_sts.open_room;
            end
            ftlgc_pkg::S_OSCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.first_ok) begin
                        o_cmd.open_take = 1'b1;
                    end else begin
                        o_cmd.open_kill = 1'b1;
                        o_cmd.emit      = 1'b1;
                        o_cmd.e_kind    = ftlgc_pkg::K_WRITE;
                        o_cmd.e_status  = ftlgc_pkg::ST_NOSPACE;
                        o_cmd.e_last    = 1'b1;
                    end
                end
            end
            ftlgc_pkg::S_PROG: begin
                o_cmd.prog = 1'b1;
            end
            ftlgc_pkg::S_PEMIT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.e_kind   = ftlgc_pkg::K_WRITE;
                o_cmd.e_status = ftlgc_pkg::ST_OK;
                o_cmd.e_src    = ftlgc_pkg::ES_PROG;
                o_cmd.e_last   = 1'b1;
            end
            default: begin
                o_cmd.latch = 1'b0;
            end
        endcase
    end

endmodule

### design/ftlgc_dp.sv
module ftlgc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ftlgc_pkg::t_req               i_req,
    input  logic                          i_cfg_we,
    input  logic [ftlgc_pkg::THR_W-1:0]   i_cfg_data,
    input  ftlgc_pkg::t_cmd               i_cmd,
    output ftlgc_pkg::t_sts               o_sts,
    output ftlgc_pkg::t_res               o_res,
    output logic                          o_res_valid
);

    localparam int PA_W  = ftlgc_pkg::PA_W;
    localparam int BLK_W = ftlgc_pkg::BLK_W;
    localparam int PG_W  = ftlgc_pkg::PG_W;
    localparam int WP_W  = ftlgc_pkg::WP_W;
    localparam int FC_W  = ftlgc_pkg::FC_W;
    localparam int LBA_W = ftlgc_pkg::LBA_W;
    localparam int LF_W  = ftlgc_pkg::LBAF_W;
    localparam int CNT_W = ftlgc_pkg::CNT_W;
    localparam int MAP_W = BLK_W + PG_W;
    localparam logic [PG_W-1:0]  PG_LAST  = PG_W'(ftlgc_pkg::PAGES_PER_BLK - 1);
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(ftlgc_pkg::BLOCK_COUNT - 1);
    localparam logic [WP_W-1:0]  WP_FULL  = WP_W'(ftlgc_pkg::PAGES_PER_BLK);

    // Memories
    logic [1:0]       ps_mem  [ftlgc_pkg::TOTAL_PAGES];
    logic [ftlgc_pkg::TOTAL_PAGES-1:0] ps_vld;
    logic [LF_W-1:0]  own_mem [ftlgc_pkg::TOTAL_PAGES];
    logic [MAP_W-1:0] map_mem [ftlgc_pkg::LBA_COUNT];
    logic [ftlgc_pkg::LBA_COUNT-1:0] map_vld;

    // Request, configuration, counters, open block
    logic [1:0]       r_action;
    logic [LF_W-1:0]  r_lba;
    logic [ftlgc_pkg::THR_W-1:0] r_thr;
    logic [CNT_W-1:0] r_hw, r_np, r_gc;
    logic             r_open_vld;
    logic [BLK_W-1:0] r_open_blk;
    logic [WP_W-1:0]  r_wp;
    logic [BLK_W-1:0] r_pl_blk;
    logic [PG_W-1:0]  r_pl_pg;
    logic [PG_W-1:0]  r_rp;

    // Read data
    logic [MAP_W-1:0] r_map_q;
    logic             r_map_hit;
    logic [1:0]       r_ps_raw;
    logic             r_ps_vq;
    logic [LF_W-1:0]  r_own_q;

    // Scan
    logic             r_sc_run, r_sc_done;
    logic [BLK_W-1:0] r_sc_blk, r_q_blk;
    logic [PG_W-1:0]  r_sc_pg, r_q_pg;
    logic             r_q_run, r_q_last;
    logic             r_acc_free;
    logic [WP_W-1:0]  r_acc_inv, r_best;
    logic [FC_W-1:0]  r_free_cnt;
    logic             r_first_ok, r_vic_ok;
    logic [BLK_W-1:0] r_first_blk, r_vic_blk;
    logic [BLK_W-1:0] r_gc_blk;

    ftlgc_pkg::t_res  r_res;
    logic             r_res_vld;

    logic             lba_ok;
    logic [LBA_W-1:0] lba_idx;
    logic [LF_W-1:0]  prog_lba;
    logic             prog_lba_ok;
    logic [LBA_W-1:0] prog_idx;
    logic [PA_W-1:0]  prog_pa;
    logic [PA_W-1:0]  old_pa;
    logic [PA_W-1:0]  rd_pa;
    logic             ps_we;
    logic [PA_W-1:0]  ps_wa;
    logic [1:0]       ps_wd;
    logic [1:0]       ps_eff;
    logic             cur_free;
    logic [WP_W-1:0]  cur_inv;
    logic             open_room;

    assign lba_ok   = ({1'b0, r_lba} < (LF_W + 1)'(ftlgc_pkg::LBA_COUNT));
    assign lba_idx  = r_lba[LBA_W-1:0];
    assign prog_lba = i_cmd.prog_reloc ? r_own_q : r_lba;
    assign prog_lba_ok = ({1'b0, prog_lba} < (LF_W + 1)'(ftlgc_pkg::LBA_COUNT));
    assign prog_idx = prog_lba[LBA_W-1:0];
    assign prog_pa  = ftlgc_pkg::pidx(r_open_blk, r_wp[PG_W-1:0]);
    assign old_pa   = ftlgc_pkg::pidx(r_map_q[MAP_W-1:PG_W], r_map_q[PG_W-1:0]);
    assign rd_pa    = r_sc_run ? ftlgc_pkg::pidx(r_sc_blk, r_sc_pg)
                               : ftlgc_pkg::pidx(r_gc_blk, r_rp);
    assign ps_eff   = r_ps_vq ? r_ps_raw : ftlgc_pkg::PG_FREE;
    assign open_room = r_open_vld && (r_wp < WP_FULL);

    // Select the page state write
    always_comb begin
        ps_we = i_cmd.prog || i_cmd.unmap_old;
        ps_wa = i_cmd.prog ? prog_pa : old_pa;
        ps_wd = i_cmd.prog ? ftlgc_pkg::PG_VALID : ftlgc_pkg::PG_INVALID;
    end

    // Page state, owner and map memories
    always_ff @(posedge i_clk) begin
        if (ps_we) ps_mem[ps_wa] <= ps_wd;
        if (i_cmd.prog) own_mem[prog_pa] <= prog_lba;
        if (i_cmd.prog && prog_lba_ok) map_mem[prog_idx] <= {r_open_blk, r_wp[PG_W-1:0]};
        r_ps_raw <= ps_mem[rd_pa];
        r_ps_vq  <= ps_vld[rd_pa];
        if (i_cmd.ps_rd) r_own_q <= own_mem[rd_pa];
        if (i_cmd.map_rd) begin
            r_map_q   <= map_mem[lba_idx];
            r_map_hit <= map_vld[lba_idx];
        end
    end

    // Valid bits: a page without one reads as free, an lba without one as unmapped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ps_vld  <= '0;
            map_vld <= '0;
        end else begin
            if (i_cmd.erase) begin
                for (int p = 0; p < ftlgc_pkg::PAGES_PER_BLK; p++) begin
                    ps_vld[ftlgc_pkg::pidx(r_gc_blk, PG_W'(p))] <= 1'b0;
                end
            end
            if (ps_we) ps_vld[ps_wa] <= 1'b1;
            if (i_cmd.unmap_old) map_vld[lba_idx] <= 1'b0;
            if (i_cmd.prog && prog_lba_ok) map_vld[prog_idx] <= 1'b1;
        end
    end

    // Latch the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_req.action;
            r_lba    <= i_req.lba;
        end
    end

    // Threshold, counters, open block, relocation page pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= ftlgc_pkg::THR_W'(1);
            r_hw       <= '0;
            r_np       <= '0;
            r_gc       <= '0;
            r_open_vld <= 1'b1;
            r_open_blk <= '0;
            r_wp       <= '0;
            r_rp       <= '0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_data;
            if (i_cmd.hw_inc) r_hw <= r_hw + 1'b1;
            if (i_cmd.gc_inc) r_gc <= r_gc + 1'b1;
            if (i_cmd.rp_clr) r_rp <= '0;
            else if (i_cmd.rp_inc) r_rp <= r_rp + 1'b1;
            if (i_cmd.open_take) begin
                r_open_vld <= 1'b1;
                r_open_blk <= r_first_blk;
                r_wp       <= '0;
            end else if (i_cmd.open_kill) begin
                r_open_vld <= 1'b0;
                r_open_blk <= '0;
                r_wp       <= '0;
            end else if (i_cmd.prog) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd.prog) r_np <= r_np + 1'b1;
        end
    end

    // Hold the placement, and the victim for the whole collection since later scans
    // overwrite the scan's victim
    always_ff @(posedge i_clk) begin
        if (i_cmd.prog) begin
            r_pl_blk <= r_open_blk;
            r_pl_pg  <= r_wp[PG_W-1:0];
        end
        if (i_cmd.rp_clr) r_gc_blk <= r_vic_blk;
    end

    // Scan: fold one page state per cycle into free count, first free and victim
    assign cur_free = r_acc_free && (ps_eff == ftlgc_pkg::PG_FREE);
    assign cur_inv  = r_acc_inv + WP_W'(ps_eff == ftlgc_pkg::PG_INVALID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_run  <= 1'b0;
            r_sc_done <= 1'b0;
            r_q_run   <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_sc_run  <= 1'b1;
            r_sc_done <= 1'b0;
            r_q_run   <= 1'b0;
        end else begin
            r_q_run <= r_sc_run;
            if (r_sc_run && r_sc_pg == PG_LAST && r_sc_blk == BLK_LAST) r_sc_run <= 1'b0;
            if (r_q_run && r_q_last) r_sc_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_sc_blk   <= '0;
            r_sc_pg    <= '0;
            r_acc_free <= 1'b1;
            r_acc_inv  <= '0;
            r_best     <= '0;
            r_free_cnt <= '0;
            r_first_ok <= 1'b0;
            r_vic_ok   <= 1'b0;
        end else begin
            if (r_sc_run) begin
                if (r_sc_pg == PG_LAST) begin
                    r_sc_pg  <= '0;
                    r_sc_blk <= r_sc_blk + 1'b1;
                end else begin
                    r_sc_pg <= r_sc_pg + 1'b1;
                end
            end
            if (r_q_run) begin
                if (r_q_pg == PG_LAST) begin
                    r_acc_free <= 1'b1;
                    r_acc_inv  <= '0;
                    if (cur_free) begin
                        r_free_cnt <= r_free_cnt + 1'b1;
                        if (!r_first_ok) begin
                            r_first_ok  <= 1'b1;
                            r_first_blk <= r_q_blk;
                        end
                    end
                    if (!(r_open_vld && r_open_blk == r_q_blk) && cur_inv > r_best) begin
                        r_best    <= cur_inv;
                        r_vic_ok  <= 1'b1;
                        r_vic_blk <= r_q_blk;
                    end
                end else begin
                    r_acc_free <= cur_free;
                    r_acc_inv  <= cur_inv;
                end
            end
        end
        r_q_blk  <= r_sc_blk;
        r_q_pg   <= r_sc_pg;
        r_q_last <= (r_sc_pg == PG_LAST) && (r_sc_blk == BLK_LAST);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.kind          <= i_cmd.e_kind;
            r_res.status        <= i_cmd.e_status;
            r_res.host_writes   <= r_hw;
            r_res.nand_programs <= r_np;
            r_res.gc_runs       <= r_gc;
            r_res.last          <= i_cmd.e_last;
            case (i_cmd.e_lsel)
                ftlgc_pkg::LS_HOST:  r_res.out_lba <= r_lba;
                ftlgc_pkg::LS_OWNER: r_res.out_lba <= r_own_q;
                default:             r_res.out_lba <= '0;
            endcase
            case (i_cmd.e_src)
                ftlgc_pkg::ES_MAP: begin
                    r_res.phys_block <= r_map_q[MAP_W-1:PG_W];
                    r_res.phys_page  <= r_map_q[PG_W-1:0];
                    r_res.mapped     <= 1'b1;
                end
                ftlgc_pkg::ES_PROG: begin
                    r_res.phys_block <= r_pl_blk;
                    r_res.phys_page  <= r_pl_pg;
                    r_res.mapped     <= 1'b1;
                end
                ftlgc_pkg::ES_ERASE: begin
                    r_res.phys_block <= r_gc_blk;
                    r_res.phys_page  <= '0;
                    r_res.mapped     <= 1'b0;
                end
                default: begin
                    r_res.phys_block <= '0;
                    r_res.phys_page  <= '0;
                    r_res.mapped     <= 1'b0;
                end
            endcase
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_vld;

    // Status to the controller
    always_comb begin
        o_sts.action    = r_action;
        o_sts.lba_bad   = !lba_ok;
        o_sts.map_hit   = r_map_hit;
        o_sts.open_room = open_room;
        o_sts.scan_done = r_sc_done;
        o_sts.gc_need   = ({1'b0, r_free_cnt} <= (FC_W + 1)'(r_thr));
        o_sts.vic_ok    = r_vic_ok;
        o_sts.first_ok  = r_first_ok;
        o_sts.pg_valid  = (ps_eff == ftlgc_pkg::PG_VALID);
        o_sts.rp_last   = (r_rp == PG_LAST);
    end

endmodule

### design/page_mapped_ftl_greedy_gc.sv
// Page-mapped flash translation layer with greedy garbage collection.
// Requests: drive i_req (action, lba) and pulse start while busy is low; the
// request is taken at that edge and busy falls as its last result is shown.
// Results: each shows on o_res for one cycle with o_res_valid high; the
// final result of a request has last set. The receiver cannot stall them.
// Configuration: i_cfg_we with i_cfg_data writes the GC free-block
// threshold; write it only while busy is low.
// Flow: range errors answer at decode, reads and trims after the map lookup,
// and a write into an open block with room programs its next page. When the
// open block is full, a scan of all BLOCK_COUNT*PAGES_PER_BLK page states
// (one page per cycle) counts free blocks and picks the victim; each victim
// page is read and checked and, when valid, relocated, with another scan when
// the open block fills; then the victim is erased, and taking a new block
// costs another scan. Worst case is three scans, when relocation finds no
// free block; the single page-state memory read port sets the scan rate.
// Reset: synchronous, active low; all lbas unmapped, all pages free, block 0
// open at page 0, counters zero, threshold 1. No clearing pass is needed.
`include "page_mapped_ftl_greedy_gc_macros.svh"

module page_mapped_ftl_greedy_gc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  ftlgc_pkg::t_req               i_req,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [ftlgc_pkg::THR_W-1:0]   i_cfg_data,
    output ftlgc_pkg::t_res               o_res,
    output logic                          o_res_valid
);

    ftlgc_pkg::t_cmd cmd;
    ftlgc_pkg::t_sts sts;

    // Sequence the request
    ftlgc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Hold tables, scan and results
    ftlgc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

    `FTLGC_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request taken but not busy")
    `FTLGC_ASSERT_NOW(a_mid_busy, o_res_valid && !o_res.last, busy, "result chain ended early")
    `FTLGC_ASSERT_NOW(a_map_ok, o_res_valid && o_res.mapped, o_res.status == ftlgc_pkg::ST_OK, "mapped result with error status")

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1500;
    localparam int LBA_COUNT      = ftlgc_pkg::LBA_COUNT;
    localparam int BLOCK_COUNT    = ftlgc_pkg::BLOCK_COUNT;
    localparam int PAGES_PER_BLK  = ftlgc_pkg::PAGES_PER_BLK;
    localparam int TOTAL_PAGES    = ftlgc_pkg::TOTAL_PAGES;
    localparam int THR_W          = ftlgc_pkg::THR_W;
    localparam int LBAF_W         = ftlgc_pkg::LBAF_W;
    localparam int BLK_W          = ftlgc_pkg::BLK_W;
    localparam int PG_W           = ftlgc_pkg::PG_W;
    localparam int CNT_W          = ftlgc_pkg::CNT_W;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    ftlgc_pkg::t_req      i_req = '0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [THR_W-1:0]     i_cfg_data = '0;
    ftlgc_pkg::t_res      o_res;
    logic                 o_res_valid;

    page_mapped_ftl_greedy_gc i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

    always #10 i_clk = ~i_clk;

    // Model state of the translation layer
    logic [THR_W-1:0]   gc_threshold;
    logic [7:0]         lba_map [LBA_COUNT];
    ftlgc_pkg::t_pstate pg_state [TOTAL_PAGES];
    logic [LBAF_W-1:0]  pg_owner [TOTAL_PAGES];
    logic               open_ok;
    logic [BLK_W-1:0]   open_blk;
    int                 wr_ptr;
    logic [CNT_W-1:0]   cnt_host, cnt_prog, cnt_gc;

    ftlgc_pkg::t_res result_queue [$];
    int   error_count = 0;
    int   request_count = 0;
    int   result_count = 0;
    int   gc_seen = 0;
    int   idle_cycles = 0;

    function automatic void model_reset();
        gc_threshold = 1;
        foreach (lba_map[i]) lba_map[i] = '0;
        foreach (pg_state[i]) begin
            pg_state[i] = ftlgc_pkg::PG_FREE;
            pg_owner[i] = '0;
        end
        open_ok = 1'b1;
        open_blk = '0;
        wr_ptr = 0;
        cnt_host = '0;
        cnt_prog = '0;
        cnt_gc = '0;
    endfunction

    function automatic bit block_free(int b);
        for (int p = 0; p < PAGES_PER_BLK; p++)
            if (pg_state[b*PAGES_PER_BLK+p] != ftlgc_pkg::PG_FREE) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_result(ftlgc_pkg::t_kind k, ftlgc_pkg::t_status s, int lba,
                                        int blk, int pg, bit m);
        ftlgc_pkg::t_res r;
        r.kind = k;
        r.status = s;
        r.out_lba = lba[LBAF_W-1:0];
        r.phys_block = blk[BLK_W-1:0];
        r.phys_page = pg[PG_W-1:0];
        r.mapped = m;
        r.host_writes = cnt_host;
        r.nand_programs = cnt_prog;
        r.gc_runs = cnt_gc;
        r.last = 1'b0;
        result_queue.push_back(r);
    endfunction

    // Make sure the open block has room; returns 0 when no free block is left
    function automatic bit open_ensure();
        if (open_ok && wr_ptr < PAGES_PER_BLK) return 1'b1;
        wr_ptr = 0;
        for (int b = 0; b < BLOCK_COUNT; b++)
            if (block_free(b)) begin
                open_ok = 1'b1;
                open_blk = b[BLK_W-1:0];
                return 1'b1;
            end
        open_ok = 1'b0;
        open_blk = '0;
        return 1'b0;
    endfunction

    function automatic void program_next(int lba, output int blk, output int pg);
        int idx;
        blk = open_blk;
        pg = wr_ptr;
        idx = blk*PAGES_PER_BLK + pg;
        pg_state[idx] = ftlgc_pkg::PG_VALID;
        pg_owner[idx] = lba[LBAF_W-1:0];
        if (lba < LBA_COUNT) lba_map[lba] = {1'b1, blk[3:0], pg[2:0]};
        cnt_prog++;
        wr_ptr++;
    endfunction

    function automatic void collect_garbage();
        int victim, best, cnt, nb, np, idx, owner;
        victim = -1;
        best = 0;
        cnt_gc++;
        gc_seen++;
        for (int b = 0; b < BLOCK_COUNT; b++) begin
            if (open_ok && open_blk == b) continue;
            cnt = 0;
            for (int p = 0; p < PAGES_PER_BLK; p++)
                if (pg_state[b*PAGES_PER_BLK+p] == ftlgc_pkg::PG_INVALID) cnt++;
            if (cnt > best) begin
                best = cnt;
                victim = b;
            end
        end
        if (victim < 0) return;
        for (int p = 0; p < PAGES_PER_BLK; p++) begin
            idx = victim*PAGES_PER_BLK + p;
            if (pg_state[idx] != ftlgc_pkg::PG_VALID) continue;
            owner = pg_owner[idx];
            if (!open_ensure()) begin
                push_result(ftlgc_pkg::K_RELOC, ftlgc_pkg::ST_NOSPACE, owner, 0, 0, 1'b0);
                return;
            end
            program_next(owner, nb, np);
            push_result(ftlgc_pkg::K_RELOC, ftlgc_pkg::ST_OK, owner, nb, np, 1'b1);
        end
        for (int p = 0; p < PAGES_PER_BLK; p++)
            pg_state[victim*PAGES_PER_BLK+p] = ftlgc_pkg::PG_FREE;
        push_result(ftlgc_pkg::K_ERASE, ftlgc_pkg::ST_OK, 0, victim, 0, 1'b0);
    endfunction

    // Work out the results of one accepted request
    function automatic void predict_request(ftlgc_pkg::t_req rq);
        int lba, nfree, nb, np;
        logic [7:0] m;
        lba = rq.lba;
        if (rq.action == ftlgc_pkg::ACT_NONE) return;
        if (lba >= LBA_COUNT) begin
            push_result(ftlgc_pkg::t_kind'({1'b0, rq.action}), ftlgc_pkg::ST_BAD_LBA, lba,
                        0, 0, 1'b0);
        end else begin
            m = lba_map[lba];
            if (rq.action == ftlgc_pkg::ACT_READ) begin
                if (m[7]) push_result(ftlgc_pkg::K_READ, ftlgc_pkg::ST_OK, lba, m[6:3], m[2:0],
                                      1'b1);
                else push_result(ftlgc_pkg::K_READ, ftlgc_pkg::ST_UNMAP, lba, 0, 0, 1'b0);
            end else if (rq.action == ftlgc_pkg::ACT_TRIM) begin
                if (m[7]) begin
                    pg_state[m[6:3]*PAGES_PER_BLK + m[2:0]] = ftlgc_pkg::PG_INVALID;
                    lba_map[lba] = '0;
                    push_result(ftlgc_pkg::K_TRIM, ftlgc_pkg::ST_OK, lba, 0, 0, 1'b0);
                end else begin
                    push_result(ftlgc_pkg::K_TRIM, ftlgc_pkg::ST_UNMAP, lba, 0, 0, 1'b0);
                end
            end else begin
                cnt_host++;
                if (m[7]) begin
                    pg_state[m[6:3]*PAGES_PER_BLK + m[2:0]] = ftlgc_pkg::PG_INVALID;
                    lba_map[lba] = '0;
                end
                if (!open_ok || wr_ptr >= PAGES_PER_BLK) begin
                    nfree = 0;
                    for (int b = 0; b < BLOCK_COUNT; b++) if (block_free(b)) nfree++;
                    if (nfree <= gc_threshold) collect_garbage();
                end
                if (!open_ensure()) begin
                    push_result(ftlgc_pkg::K_WRITE, ftlgc_pkg::ST_NOSPACE, lba, 0, 0, 1'b0);
                end else begin
                    program_next(lba, nb, np);
                    push_result(ftlgc_pkg::K_WRITE, ftlgc_pkg::ST_OK, lba, nb, np, 1'b1);
                end
            end
        end
        result_queue[$].last = 1'b1;
    endfunction

    // Compare each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        ftlgc_pkg::t_res exp_res;
        if (i_rst_n && o_res_valid) begin
            result_count++;
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $realtime, o_res);
                error_count++;
            end else begin
                exp_res = result_queue.pop_front();
                if (o_res !== exp_res) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $realtime, exp_res, o_res);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", result_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    int burst_left = 0;

    // Send one request, with bursty random gaps ahead of it
    task automatic send_request(ftlgc_pkg::t_action act, int lba);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge i_clk);
        end
        burst_left--;
        start <= 1'b1;
        i_req <= '{action: act, lba: lba[LBAF_W-1:0]};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_request(i_req);
        request_count++;
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= '{action: ftlgc_pkg::t_action'($urandom_range(0, 3)),
                   lba: LBAF_W'($urandom)};
    endtask

    // Hold off until every expected result is in and the block is idle
    task automatic wait_drained();
        @(negedge i_clk);
        while (result_queue.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_threshold(int value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value[THR_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gc_threshold = value[THR_W-1:0];
    endtask

    task automatic test_directed();
        send_request(ftlgc_pkg::ACT_READ, 0);
        send_request(ftlgc_pkg::ACT_TRIM, 5);
        send_request(ftlgc_pkg::ACT_WRITE, 0);
        send_request(ftlgc_pkg::ACT_WRITE, LBA_COUNT - 1);
        send_request(ftlgc_pkg::ACT_READ, LBA_COUNT - 1);
        send_request(ftlgc_pkg::ACT_WRITE, 0);
        send_request(ftlgc_pkg::ACT_READ, 0);
        send_request(ftlgc_pkg::ACT_TRIM, 0);
        send_request(ftlgc_pkg::ACT_READ, 0);
        send_request(ftlgc_pkg::ACT_WRITE, 127);
        send_request(ftlgc_pkg::ACT_READ, 64);
        send_request(ftlgc_pkg::ACT_TRIM, 85);
        send_request(ftlgc_pkg::ACT_NONE, 3);
        send_request(ftlgc_pkg::ACT_NONE, 127);
        send_request(ftlgc_pkg::ACT_READ, 42);
    endtask

    // Overwrite lbas below hot so blocks fill with stale pages and GC runs
    task automatic test_gc_churn(int count, int hot);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) send_request(ftlgc_pkg::ACT_WRITE, $urandom_range(0, hot - 1));
            else if (r < 80) send_request(ftlgc_pkg::ACT_READ, $urandom_range(0, LBA_COUNT - 1));
            else if (r < 90) send_request(ftlgc_pkg::ACT_TRIM, $urandom_range(0, hot - 1));
            else send_request(ftlgc_pkg::t_action'($urandom_range(0, 3)),
                              $urandom_range(0, 127));
        end
    endtask

    // Map every lba once while GC keeps reclaiming blocks
    task automatic test_fill_device();
        for (int i = 0; i < LBA_COUNT; i++) send_request(ftlgc_pkg::ACT_WRITE, i);
    endtask

    initial begin
        model_reset();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        write_threshold(16);
        test_gc_churn(25, 10);
        write_threshold(0);
        test_gc_churn(15, 24);
        write_threshold(3);
        test_gc_churn(15, LBA_COUNT);
        write_threshold(16);
        test_fill_device();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("%0d requests, %0d results, %0d GC runs over thresholds 0..16",
                 request_count, result_count, gc_seen);
        if (error_count == 0 && result_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results missing", error_count, result_queue.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### files.f
+incdir+design
design/ftlgc_pkg.sv
design/ftlgc_ctrl.sv
design/ftlgc_dp.sv
design/page_mapped_ftl_greedy_gc.sv
test/tb.sv
